>>> rtl/core/kpmc_pkg.sv
`default_nettype none

package kpmc_pkg;

  typedef enum logic [1:0] {
    ModeNormal = 2'd0,
    ModeLogin  = 2'd1,
    ModeMenu   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    CfgPasscode   = 2'd0,
    CfgDebounce   = 2'd1,
    CfgEntryCount = 2'd2
  } cfg_reg_e;

  localparam int unsigned NumButtons = 14;

  // Button bit positions in the poll.
  localparam int unsigned BtnNine    = 8;
  localparam int unsigned BtnTen     = 9;
  localparam int unsigned BtnEleven  = 10;
  localparam int unsigned BtnDelete  = 12;
  localparam int unsigned BtnConfirm = 13;

  localparam int unsigned MaxEntries   = 16;
  localparam logic [4:0]  CountLimit   = (MaxEntries < 16) ? 5'(MaxEntries) : 5'd16;
  localparam logic [3:0]  EmptyDigit   = 4'hf;
  localparam logic [15:0] EmptyEntry   = 16'hffff;
  localparam logic [15:0] PasscodeRst  = 16'h2004;
  localparam logic [15:0] DebounceRst  = 16'd200;
  localparam logic [4:0]  EntryCntRst  = 5'd2;

  localparam logic [NumButtons-1:0] LoginMask  = 14'b11_0011_1111_1111;
  localparam logic [NumButtons-1:0] MenuMask   = 14'b00_0111_0000_0000;
  localparam logic [NumButtons-1:0] NormalMask = 14'b00_0100_0000_0000;

  typedef struct packed {
    logic        send_now;
    logic        login_failed;
    logic        login_ok;
    logic        entry_committed;
    logic [3:0]  selected_entry;
    logic [3:0]  cursor;
    logic [15:0] entered_digits;
    logic [2:0]  digit_count;
    logic [1:0]  mode;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/keypad_passcode_menu_controller.sv
// Keypad passcode and menu controller.
// Each input item on the s_axis channel is one keypad poll: the millisecond time
// and fourteen pressed flags. Every poll yields exactly one result item on the
// m_axis channel with the mode, the digit entry, the menu cursor, the committed
// entry and the event flags of that poll.
// An item is taken into an input register, processed combinationally against
// the debounce timestamps and mode state, and lands in an output register.
// The result item is registered once the output register is free, and one
// item is accepted every cycle while the receiver keeps taking results.
// When the receiver stalls, the output register holds its result and the input
// register holds one more item; input is then held off until the stall clears.
// The APB port reads and writes the passcode, debounce delay and entry count;
// it is to be written only while no item is in flight, which the block does not enforce.
// Reset puts the block in normal mode with an empty entry, cursor and selection
// at zero, all button timestamps at zero and the registers at their defaults.
`default_nettype none

module keypad_passcode_menu_controller
  import kpmc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [31:0] now_ms, [45:32] buttons, [47:46] zero
  input  wire logic [47:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [1:0] mode, [4:2] digit_count, [20:5] entered_digits, [24:21] cursor,
  // [28:25] selected_entry, [29] entry_committed, [30] login_ok,
  // [31] login_failed, [32] send_now, [39:33] zero
  output logic [39:0]      m_axis_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [15:0] passcode_q;
  logic [15:0] debounce_q;
  logic [4:0]  entry_cnt_q;

  logic                  in_valid_q;
  logic [31:0]           in_now_q;
  logic [NumButtons-1:0] in_btn_q;

  logic    out_valid_q;
  result_t out_res_q;
  result_t res;

  mode_e       mode_q, mode_d;
  logic [15:0] digits_q, digits_d;
  logic [2:0]  digit_idx_q, digit_idx_d;
  logic [3:0]  cursor_q, cursor_d;
  logic [3:0]  selected_q, selected_d;
  logic [31:0] press_time_q [NumButtons];

  logic                  advance;
  logic                  cfg_wr;
  logic [NumButtons-1:0] debounced;
  logic [NumButtons-1:0] accepted;
  logic [4:0]            count;
  logic                  ev_enter, ev_ok, ev_fail, ev_commit;

  assign pready        = 1'b1;
  assign cfg_wr        = psel && penable && pwrite;
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_res_q};

  always_comb begin
    unique case (cfg_reg_e'(paddr[3:2]))
      CfgPasscode:   prdata = {16'd0, passcode_q};
      CfgDebounce:   prdata = {16'd0, debounce_q};
      CfgEntryCount: prdata = {27'd0, entry_cnt_q};
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      passcode_q  <= PasscodeRst;
      debounce_q  <= DebounceRst;
      entry_cnt_q <= EntryCntRst;
    end else if (cfg_wr) begin
      case (cfg_reg_e'(paddr[3:2]))
        CfgPasscode:   passcode_q  <= pwdata[15:0];
        CfgDebounce:   debounce_q  <= pwdata[15:0];
        CfgEntryCount: entry_cnt_q <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int b = 0; b < NumButtons; b++) begin
      debounced[b] = in_btn_q[b] &&
                     ((in_now_q - press_time_q[b]) > {16'd0, debounce_q});
    end
    case (mode_q)
      ModeLogin: accepted = debounced & LoginMask;
      ModeMenu:  accepted = debounced & MenuMask;
      default:   accepted = debounced & NormalMask;
    endcase
  end

  always_comb begin
    if (entry_cnt_q == 5'd0) begin
      count = 5'd1;
    end else if (entry_cnt_q > CountLimit) begin
      count = CountLimit;
    end else begin
      count = entry_cnt_q;
    end
  end

  // Digit entry and menu datapath; login buttons are applied in ascending order.
  always_comb begin
    logic [2:0]  idx;
    logic [15:0] dig;
    logic [3:0]  cur;
    idx        = digit_idx_q;
    dig        = digits_q;
    cur        = cursor_q;
    selected_d = selected_q;
    ev_enter   = 1'b0;
    ev_ok      = 1'b0;
    ev_fail    = 1'b0;
    ev_commit  = 1'b0;
    case (mode_q)
      ModeLogin: begin
        for (int b = 0; b <= BtnTen; b++) begin
          if (accepted[b] && !idx[2]) begin
            dig[(2'd3 - idx[1:0]) * 4 +: 4] = (b == BtnTen) ? 4'd0 : 4'(b + 1);
            idx = idx + 3'd1;
          end
        end
        if (accepted[BtnDelete] && (idx != 3'd0)) begin
          idx = idx - 3'd1;
          dig[(2'd3 - idx[1:0]) * 4 +: 4] = EmptyDigit;
        end
        if (accepted[BtnConfirm] && idx[2]) begin
          if (dig == passcode_q) begin
            ev_ok = 1'b1;
            cur   = selected_q;
          end else begin
            ev_fail = 1'b1;
            dig     = EmptyEntry;
            idx     = 3'd0;
          end
        end
      end
      ModeMenu: begin
        if (accepted[BtnEleven]) begin
          cur = (cur == 4'd0) ? 4'(count - 5'd1) : cur - 4'd1;
        end
        if (accepted[BtnNine]) begin
          cur = (({1'b0, cur} + 5'd1) >= count) ? 4'd0 : cur + 4'd1;
        end
        if (accepted[BtnTen]) begin
          selected_d = cur;
          ev_commit  = 1'b1;
        end
      end
      default: begin
        if (accepted[BtnEleven]) begin
          ev_enter = 1'b1;
          dig      = EmptyEntry;
          idx      = 3'd0;
        end
      end
    endcase
    digits_d    = dig;
    digit_idx_d = idx;
    cursor_d    = cur;
  end

  always_comb begin
    mode_d = mode_q;
    unique case (mode_q)
      ModeLogin: begin
        if (ev_ok) begin
          mode_d = ModeMenu;
        end else if (ev_fail) begin
          mode_d = ModeNormal;
        end
      end
      ModeMenu: begin
        if (ev_commit) begin
          mode_d = ModeNormal;
        end
      end
      default: begin
        mode_d = ev_enter ? ModeLogin : ModeNormal;
      end
    endcase
  end

  always_comb begin
    res.mode            = mode_d;
    res.digit_count     = digit_idx_d;
    res.entered_digits  = digits_d;
    res.cursor          = cursor_d;
    res.selected_entry  = selected_d;
    res.entry_committed = ev_commit;
    res.login_ok        = ev_ok;
    res.login_failed    = ev_fail;
    res.send_now        = (mode_q != ModeLogin) && (mode_q != ModeMenu) && !ev_enter;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= ModeNormal;
      digits_q    <= EmptyEntry;
      digit_idx_q <= 3'd0;
      cursor_q    <= 4'd0;
      selected_q  <= 4'd0;
      for (int b = 0; b < NumButtons; b++) begin
        press_time_q[b] <= 32'd0;
      end
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (advance) begin
        mode_q      <= mode_d;
        digits_q    <= digits_d;
        digit_idx_q <= digit_idx_d;
        cursor_q    <= cursor_d;
        selected_q  <= selected_d;
        for (int b = 0; b < NumButtons; b++) begin
          if (accepted[b]) begin
            press_time_q[b] <= in_now_q;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_now_q <= s_axis_tdata[31:0];
      in_btn_q <= s_axis_tdata[45:32];
    end
    if (advance) begin
      out_res_q <= res;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    digit_idx_q <= 3'd4)
    else $error("Digit count exceeds four.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_res_q.login_ok && out_res_q.login_failed))
    else $error("Login reported as both matched and mismatched.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.send_now) |-> (out_res_q.mode == ModeNormal))
    else $error("Send raised outside normal mode.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready && !advance) |=> (out_valid_q && $stable(out_res_q)))
    else $error("Stalled result changed.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && ev_ok) |=> (mode_q == ModeMenu && cursor_q == selected_q))
    else $error("Passcode match did not open the menu at the selection.");

endmodule

`default_nettype wire
